// ===== src/constant_power_bus_panner_mixer_unit_defines.svh =====
// Assertion macros for the panning mixer.
// Used by the top level only; expects clk and rst in scope.
`ifndef CONSTANT_POWER_BUS_PANNER_MIXER_UNIT_DEFINES_SVH
`define CONSTANT_POWER_BUS_PANNER_MIXER_UNIT_DEFINES_SVH

// same-cycle implication
`define CPBPM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpbpm: same-cycle check failed");

// next-cycle implication
`define CPBPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpbpm: next-cycle check failed");

`endif

// ===== src/cpbpm_pkg.sv =====
// Shared types and constants for the panning mixer.
// No dependencies; imported by every module of the block.
package cpbpm_pkg;

  localparam int DRY_BUSES_DEF = 5;
  localparam int SINE_ENTRIES_DEF = 256;
  localparam int ACC_WIDTH_DEF = 40;

  localparam int SAMPLE_W = 16;
  localparam int MAG_W = 17;
  localparam int BUS_IDX_W = 4;
  localparam int ACC_LO_W = 24;

  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    MODE_VOICE  = 2'd0,
    MODE_REVERB = 2'd1,
    MODE_CD     = 2'd2,
    MODE_EOF    = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DEC, ST_DIV, ST_IDX, ST_RD, ST_GAIN, ST_MUL,
    ST_PLOAD, ST_ADD, ST_OMUL, ST_OSUM, ST_OSAT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DEC, OP_IDX, OP_RD, OP_GAIN, OP_MUL,
    OP_PLOAD, OP_ADD, OP_OMUL, OP_OSUM, OP_OUT
  } dp_op_t;

  typedef struct packed {
    mode_t mode;
    logic  silent;
    logic  div_busy;
    logic  phase;
    logic  last_bus;
    logic  out_free;
  } dp_status_t;

endpackage

// ===== src/cpbpm_div.sv =====
// Restoring divider, one quotient bit per cycle, for the pan position.
// Depends on cpbpm_pkg. Quotient is floor(num * 2^16 / den).
module cpbpm_div #(
  parameter int SEG_W = 3
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [cpbpm_pkg::SAMPLE_W+SEG_W-1:0] num,
  input  logic [cpbpm_pkg::MAG_W-1:0]          den,
  output logic                                 busy,
  output logic [SEG_W+15:0]                    quo
);
  import cpbpm_pkg::*;

  localparam int QW = SEG_W + 16;
  localparam int CW = $clog2(QW + 1);

  logic [MAG_W-1:0] rem;
  logic [QW-1:0]    sh;
  logic [CW-1:0]    cnt;
  logic [MAG_W:0]   trial;

  assign trial = {rem, sh[QW-1]};
  assign quo = sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CW'(QW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      busy <= (cnt != CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // top bits of the dividend are known to be below den
      rem <= MAG_W'(num >> SEG_W);
      sh <= {num[SEG_W-1:0], 16'd0};
    end else if (busy) begin
      if (trial >= {1'b0, den}) begin
        rem <= MAG_W'(trial - {1'b0, den});
        sh <= {sh[QW-2:0], 1'b1};
      end else begin
        rem <= trial[MAG_W-1:0];
        sh <= {sh[QW-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== src/cpbpm_ctrl.sv =====
// Sequencer for the panning mixer: walks voice, pair and end-of-frame items.
// Depends on cpbpm_pkg; drives the datapath by op codes.
module cpbpm_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  cpbpm_pkg::dp_status_t  status,
  output cpbpm_pkg::dp_op_t      op
);
  import cpbpm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op = OP_NONE;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op = OP_LOAD;
          state_next = ST_DEC;
        end
      end
      ST_DEC: begin
        op = OP_DEC;
        case (status.mode)
          MODE_VOICE:  state_next = status.silent ? ST_IDLE : ST_DIV;
          MODE_EOF:    state_next = ST_OMUL;
          default:     state_next = ST_PLOAD;
        endcase
      end
      ST_DIV: begin
        if (!status.div_busy) begin
          state_next = ST_IDX;
        end
      end
      ST_IDX: begin
        op = OP_IDX;
        state_next = ST_RD;
      end
      ST_RD: begin
        op = OP_RD;
        state_next = ST_GAIN;
      end
      ST_GAIN: begin
        op = OP_GAIN;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        op = OP_MUL;
        state_next = ST_ADD;
      end
      ST_PLOAD: begin
        op = OP_PLOAD;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        op = OP_ADD;
        if (status.phase) begin
          state_next = ST_IDLE;
        end else if (status.mode == MODE_VOICE) begin
          state_next = ST_RD;
        end else begin
          state_next = ST_PLOAD;
        end
      end
      ST_OMUL: begin
        op = OP_OMUL;
        state_next = ST_OSUM;
      end
      ST_OSUM: begin
        op = OP_OSUM;
        state_next = ST_OSAT;
      end
      ST_OSAT: begin
        if (status.out_free) begin
          op = OP_OUT;
          state_next = status.last_bus ? ST_IDLE : ST_OMUL;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== src/cpbpm_dp.sv =====
// Datapath: input latch, pan divider, sine ROM, gain multipliers,
// bus accumulators and output register. Depends on cpbpm_pkg, cpbpm_div.
module cpbpm_dp #(
  parameter int DRY_BUSES = cpbpm_pkg::DRY_BUSES_DEF,
  parameter int SINE_TABLE_ENTRIES = cpbpm_pkg::SINE_ENTRIES_DEF,
  parameter int ACC_WIDTH = cpbpm_pkg::ACC_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  cpbpm_pkg::dp_op_t                   op,
  output cpbpm_pkg::dp_status_t               status,
  input  logic [1:0]                          in_mode,
  input  logic [cpbpm_pkg::SAMPLE_W-1:0]      in_sl,
  input  logic [cpbpm_pkg::SAMPLE_W-1:0]      in_sr,
  input  logic [cpbpm_pkg::SAMPLE_W-1:0]      in_vl,
  input  logic [cpbpm_pkg::SAMPLE_W-1:0]      in_vr,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cpbpm_pkg::BUS_IDX_W-1:0]     out_index,
  output logic [cpbpm_pkg::SAMPLE_W-1:0]      out_sample,
  output logic                                out_last
);
  import cpbpm_pkg::*;

  localparam int SEG_W = $clog2(DRY_BUSES);
  localparam int QW = SEG_W + 16;
  localparam int NW = SAMPLE_W + SEG_W;
  localparam int NB = DRY_BUSES + 4;
  localparam int BW = $clog2(NB);
  localparam int IW = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int FW = MAG_W + IW + 1;
  localparam int HW = ACC_WIDTH - ACC_LO_W;
  localparam int LPW = ACC_LO_W + MAG_W;
  localparam int HPW = HW + MAG_W + 1;
  localparam int TW = ACC_WIDTH + MAG_W + 1;
  localparam logic [MAG_W-1:0] UNITY = MAG_W'(32768);

  // quarter-wave sine table, built at elaboration
  logic [15:0] rom [SINE_TABLE_ENTRIES+1];
  for (genvar i = 0; i <= SINE_TABLE_ENTRIES; i++) begin : g_rom
    localparam longint unsigned X = (HALF_PI_Q30 * i) / SINE_TABLE_ENTRIES;
    localparam longint unsigned X2 = (X * X) >> 30;
    localparam longint unsigned A1 = ONE_Q30 - X2 / 72;
    localparam longint unsigned A2 = ONE_Q30 - ((X2 * A1) >> 30) / 42;
    localparam longint unsigned A3 = ONE_Q30 - ((X2 * A2) >> 30) / 20;
    localparam longint unsigned A4 = ONE_Q30 - ((X2 * A3) >> 30) / 6;
    localparam longint unsigned S0 = (X * A4) >> 30;
    localparam longint unsigned S1 = (S0 + 16384) >> 15;
    localparam longint unsigned SV = (S1 >= 32767) ? 32767 : S1;
    assign rom[i] = 16'(SV);
  end

  // input-side magnitudes and gains
  logic [MAG_W-1:0] lmag_c, rmag_c, vmax_c, gain_c, master_c;
  logic signed [SAMPLE_W-1:0] mmax_c;

  always_comb begin
    lmag_c = in_vl[15] ? (MAG_W'(0) - {in_vl[15], in_vl}) : {1'b0, in_vl};
    rmag_c = in_vr[15] ? (MAG_W'(0) - {in_vr[15], in_vr}) : {1'b0, in_vr};
    vmax_c = (lmag_c > rmag_c) ? lmag_c : rmag_c;
    gain_c = (vmax_c >= MAG_W'(32767)) ? UNITY : vmax_c;
    mmax_c = ($signed(in_vl) > $signed(in_vr)) ? $signed(in_vl) : $signed(in_vr);
    if (mmax_c <= 0) begin
      master_c = '0;
    end else if (mmax_c == 16'sd32767) begin
      master_c = UNITY;
    end else begin
      master_c = {1'b0, mmax_c};
    end
  end

  mode_t            mode;
  logic [SAMPLE_W-1:0] smp, smp_r;
  logic [MAG_W-1:0] rmag, sum, gain, master;
  logic             silent;

  always_ff @(posedge clk) begin
    if (op == OP_LOAD) begin
      mode <= mode_t'(in_mode);
      smp <= in_sl;
      smp_r <= in_sr;
      rmag <= rmag_c;
      sum <= lmag_c + rmag_c;
      gain <= gain_c;
      master <= master_c;
      silent <= (lmag_c == '0) && (rmag_c == '0);
    end
  end

  // pan position
  logic          div_start, div_busy;
  logic [QW-1:0] quo;
  logic [NW-1:0] num;

  assign num = NW'(rmag) * NW'(DRY_BUSES - 1);
  assign div_start = (op == OP_DEC) && (mode == MODE_VOICE) && !silent;

  cpbpm_div #(.SEG_W(SEG_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (sum),
    .busy  (div_busy),
    .quo   (quo)
  );

  logic [SEG_W-1:0] seg, seg_n;
  logic [MAG_W-1:0] frac_n;
  logic [FW-1:0]    idx_full;
  logic [IW-1:0]    idx, rd_addr;
  logic             phase;

  always_comb begin
    seg_n = quo[QW-1:16];
    frac_n = {1'b0, quo[15:0]};
    // exactly on an inner bus: use the segment below at full fraction
    if (seg_n != '0 && quo[15:0] == '0) begin
      seg_n = seg_n - 1'b1;
      frac_n = UNITY << 1;
    end
    if (seg_n >= SEG_W'(DRY_BUSES - 1)) begin
      seg_n = SEG_W'(DRY_BUSES - 2);
      frac_n = UNITY << 1;
    end
    idx_full = FW'(frac_n) * FW'(SINE_TABLE_ENTRIES) + FW'(32768);
  end

  assign rd_addr = phase ? idx : (IW'(SINE_TABLE_ENTRIES) - idx);

  logic [MAG_W-1:0]     rom_q, bgain;
  logic [2*MAG_W-1:0]   bprod;
  logic signed [SAMPLE_W+MAG_W:0] mul_v;
  logic signed [SAMPLE_W+14:0]    pair_v;
  logic signed [ACC_WIDTH-1:0]    prod;

  assign bprod = rom_q * gain;
  assign mul_v = $signed(smp) * $signed({1'b0, bgain});
  assign pair_v = $signed({(phase ? smp_r : smp), 15'd0});

  always_ff @(posedge clk) begin
    case (op)
      OP_IDX: begin
        seg <= seg_n;
        idx <= IW'(idx_full >> 16);
      end
      OP_RD: begin
        rom_q <= (rd_addr == IW'(SINE_TABLE_ENTRIES)) ? UNITY : {1'b0, rom[rd_addr]};
      end
      OP_GAIN:  bgain <= MAG_W'(bprod >> 15);
      OP_MUL:   prod <= ACC_WIDTH'(mul_v);
      OP_PLOAD: prod <= ACC_WIDTH'(pair_v);
      default: ;
    endcase
  end

  // accumulators
  logic signed [ACC_WIDTH-1:0] acc [NB];
  logic [BW-1:0] bptr, tgt, acc_addr;
  logic signed [ACC_WIDTH-1:0] acc_rd, acc_sat;
  logic signed [ACC_WIDTH:0]   acc_sum;

  always_comb begin
    if (mode == MODE_VOICE) begin
      tgt = BW'(seg) + BW'(phase);
    end else begin
      tgt = BW'(DRY_BUSES) + ((mode == MODE_CD) ? BW'(2) : BW'(0)) + BW'(phase);
    end
    acc_addr = (mode == MODE_EOF) ? bptr : tgt;
    acc_rd = acc[acc_addr];
    acc_sum = {acc_rd[ACC_WIDTH-1], acc_rd} + {prod[ACC_WIDTH-1], prod};
    if (acc_sum[ACC_WIDTH] != acc_sum[ACC_WIDTH-1]) begin
      acc_sat = acc_sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                   : {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[ACC_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < NB; b++) begin
        acc[b] <= '0;
      end
      phase <= 1'b0;
      bptr <= '0;
    end else begin
      case (op)
        OP_DEC: begin
          phase <= 1'b0;
          bptr <= '0;
        end
        OP_ADD: begin
          acc[acc_addr] <= acc_sat;
          phase <= ~phase;
        end
        OP_OUT: begin
          acc[acc_addr] <= '0;
          bptr <= bptr + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // master scaling, split into low and high partial products
  logic [LPW-1:0]         plo;
  logic signed [HPW-1:0]  phi;
  logic signed [TW-1:0]   tot, biased, shifted;
  logic [SAMPLE_W-1:0]    sat_v;

  always_ff @(posedge clk) begin
    case (op)
      OP_OMUL: begin
        plo <= acc_rd[ACC_LO_W-1:0] * master;
        phi <= $signed(acc_rd[ACC_WIDTH-1:ACC_LO_W]) * $signed({1'b0, master});
      end
      OP_OSUM: tot <= (TW'(phi) <<< ACC_LO_W) + TW'($signed({1'b0, plo}));
      default: ;
    endcase
  end

  always_comb begin
    // truncate toward zero
    biased = tot + (tot[TW-1] ? TW'((64'd1 << 30) - 1) : TW'(0));
    shifted = biased >>> 30;
    if (shifted > TW'(32767)) begin
      sat_v = 16'h7fff;
    end else if (shifted < -TW'(32768)) begin
      sat_v = 16'h8000;
    end else begin
      sat_v = shifted[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_OUT) begin
      out_index <= BUS_IDX_W'(bptr);
      out_sample <= sat_v;
      out_last <= (bptr == BW'(NB - 1));
    end
  end

  always_comb begin
    status.mode = mode;
    status.silent = silent;
    status.div_busy = div_busy;
    status.phase = phase;
    status.last_bus = (bptr == BW'(NB - 1));
    status.out_free = !out_valid || out_ready;
  end

endmodule

// ===== src/constant_power_bus_panner_mixer_unit.sv =====
// Constant-power panning mixer. A voice item's time is set by the bit-serial
// pan divider plus the two-pass ROM/gain/accumulate sequence; an end of frame
// emits the buses one at a time, waiting while the sink stalls. One item at a
// time. Synchronous reset clears the sequencer, the output valid flag and all
// bus accumulators.
`include "constant_power_bus_panner_mixer_unit_defines.svh"

module constant_power_bus_panner_mixer_unit #(
  parameter int DRY_BUSES = cpbpm_pkg::DRY_BUSES_DEF,
  parameter int SINE_TABLE_ENTRIES = cpbpm_pkg::SINE_ENTRIES_DEF,
  parameter int ACC_WIDTH = cpbpm_pkg::ACC_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // sample_left, sample_right, vol_left, vol_right
  input  logic [1:0]  s_tuser,  // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // bus_sample
  output logic [3:0]  m_tuser,  // bus_index
  output logic        m_tlast
);
  import cpbpm_pkg::*;

  dp_op_t     op;
  dp_status_t status;

  cpbpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .op       (op)
  );

  cpbpm_dp #(
    .DRY_BUSES          (DRY_BUSES),
    .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES),
    .ACC_WIDTH          (ACC_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .status     (status),
    .in_mode    (s_tuser),
    .in_sl      (s_tdata[15:0]),
    .in_sr      (s_tdata[31:16]),
    .in_vl      (s_tdata[47:32]),
    .in_vr      (s_tdata[63:48]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_index  (m_tuser),
    .out_sample (m_tdata),
    .out_last   (m_tlast)
  );

  `CPBPM_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  `CPBPM_ASSERT_NOW(a_last_is_cd_right, m_tvalid && m_tlast, m_tuser == 4'(DRY_BUSES + 3))
  `CPBPM_ASSERT_NEXT(a_out_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the constant-power panning mixer: random and directed items,
// self-checked against a bit-accurate mixer model held in a scoreboard class.
// Depends on cpbpm_pkg and the RTL top level constant_power_bus_panner_mixer_unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cpbpm_pkg::*;

  localparam int NBUS = DRY_BUSES_DEF + 4;
  localparam int NSIN = SINE_ENTRIES_DEF;
  localparam longint ACC_HI = (64'sd1 <<< (ACC_WIDTH_DEF - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;

  typedef struct {
    logic [3:0]  idx;
    logic [15:0] smp;
    logic        lst;
  } bus_out_t;

  class mixer_scoreboard;
    longint acc[NBUS];
    longint sine[NSIN + 1];
    bus_out_t pending[$];
    int errors;

    function new();
      longint unsigned x, x2, a, s;
      for (int i = 0; i <= NSIN; i++) begin
        x = (HALF_PI_Q30 * i) / NSIN;
        x2 = (x * x) >> 30;
        a = ONE_Q30 - x2 / 72;
        a = ONE_Q30 - ((x2 * a) >> 30) / 42;
        a = ONE_Q30 - ((x2 * a) >> 30) / 20;
        a = ONE_Q30 - ((x2 * a) >> 30) / 6;
        s = ((x * a) >> 30);
        s = (s + 16384) >> 15;
        sine[i] = (s > 32767) ? 32767 : s;
      end
      foreach (acc[b]) acc[b] = 0;
      errors = 0;
    endfunction

    function longint gain_q15(longint m);
      longint g;
      if (m <= 0) return 0;
      g = (m * 32768) / 32767;
      return g > 32768 ? 32768 : g;
    endfunction

    function longint sine_at(int i);
      if (i >= NSIN) return 32768;
      if (i <= 0) return 0;
      return sine[i];
    endfunction

    function void sat_add(int b, longint v);
      longint s;
      s = acc[b] + v;
      if (s > ACC_HI) s = ACC_HI;
      if (s < ACC_LO) s = ACC_LO;
      acc[b] = s;
    endfunction

    function void note_item(mode_t md, logic signed [15:0] sl, logic signed [15:0] sr,
                            logic signed [15:0] vl, logic signed [15:0] vr);
      longint l, r, sum, g, num, seg, frac, m, p;
      int ix;
      bus_out_t o;
      case (md)
        MODE_VOICE: begin
          l = vl < 0 ? -longint'(vl) : vl;
          r = vr < 0 ? -longint'(vr) : vr;
          sum = l + r;
          if (sum > 0) begin
            g = gain_q15(l > r ? l : r);
            num = r * (DRY_BUSES_DEF - 1);
            seg = num / sum;
            frac = ((num % sum) * 65536) / sum;
            if (seg > 0 && frac == 0) begin
              seg -= 1;
              frac = 65536;
            end
            if (seg >= DRY_BUSES_DEF - 1) begin
              seg = DRY_BUSES_DEF - 2;
              frac = 65536;
            end
            ix = int'((frac * NSIN + 32768) >>> 16);
            sat_add(int'(seg), longint'(sl) * ((sine_at(NSIN - ix) * g) >>> 15));
            sat_add(int'(seg) + 1, longint'(sl) * ((sine_at(ix) * g) >>> 15));
          end
        end
        MODE_REVERB, MODE_CD: begin
          ix = DRY_BUSES_DEF + (md == MODE_CD ? 2 : 0);
          sat_add(ix, longint'(sl) * 32768);
          sat_add(ix + 1, longint'(sr) * 32768);
        end
        default: begin
          m = gain_q15(vl > vr ? vl : vr);
          for (int b = 0; b < NBUS; b++) begin
            p = (acc[b] * m) / (64'sd1 <<< 30);
            if (p > 32767) p = 32767;
            if (p < -32768) p = -32768;
            o.idx = 4'(b);
            o.smp = p[15:0];
            o.lst = (b == NBUS - 1);
            pending.push_back(o);
            acc[b] = 0;
          end
        end
      endcase
    endfunction

    function void check_bus(logic [3:0] idx, logic [15:0] smp, logic lst);
      bus_out_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected bus output idx=%0d sample=%0d", idx, $signed(smp));
        return;
      end
      e = pending.pop_front();
      if (e.idx !== idx || e.smp !== smp || e.lst !== lst) begin
        errors++;
        if (errors <= 10)
          $display("bus mismatch: exp idx=%0d smp=%0d last=%0b got idx=%0d smp=%0d last=%0b",
                   e.idx, $signed(e.smp), e.lst, idx, $signed(smp), lst);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid, m_tready = 0, m_tlast;
  logic [15:0] m_tdata;
  logic [3:0] m_tuser;

  mixer_scoreboard mix = new();
  int cycles = 0;
  bit hold_off = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  constant_power_bus_panner_mixer_unit dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // sink: own stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) mix.check_bus(m_tuser, m_tdata, m_tlast);
    if (hold_off) m_tready <= 0;
    else if (cycles % 64 < 20) m_tready <= 1;
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  int gap_left = 0;

  task automatic send(mode_t md, logic [15:0] sl, logic [15:0] sr,
                      logic [15:0] vl, logic [15:0] vr);
    if (gap_left > 0) begin
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end else if ($urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 12);
    s_tvalid <= 1;
    s_tuser <= md;
    s_tdata <= {vr, vl, sr, sl};
    do @(posedge clk); while (!s_tready);
    mix.note_item(md, sl, sr, vl, vr);
    if (gap_left > 0) s_tvalid <= 0;
  endtask

  function automatic logic [15:0] rnd16();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    mode_t md;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, silent voice, bus boundaries, hard right, masters
    send(MODE_VOICE, 16'h7fff, 16'h0, 16'h7fff, 16'h0);
    send(MODE_VOICE, 16'h8000, 16'h0, 16'h0, 16'h8000);
    send(MODE_VOICE, 16'h1234, 16'h0, 16'd300, 16'd100);
    send(MODE_VOICE, 16'h4000, 16'h0, 16'd100, 16'd100);
    send(MODE_VOICE, 16'h7fff, 16'h0, 16'h0, 16'h0);
    send(MODE_VOICE, 16'hc000, 16'hffff, 16'h8000, 16'h7fff);
    send(MODE_REVERB, 16'h7fff, 16'h8000, 16'h0, 16'h0);
    send(MODE_CD, 16'h8000, 16'h7fff, 16'hffff, 16'hffff);
    send(MODE_EOF, 16'h0, 16'h0, 16'h7fff, 16'h8000);
    send(MODE_VOICE, 16'h7fff, 16'h0, 16'd100, 16'd300);
    send(MODE_REVERB, 16'h1000, 16'hf000, 16'h0, 16'h0);
    send(MODE_EOF, 16'h0, 16'h0, 16'h8000, 16'hffff);
    send(MODE_CD, 16'h7fff, 16'h7fff, 16'h0, 16'h0);
    send(MODE_EOF, 16'hffff, 16'hffff, 16'h4000, 16'h2000);
    // pile up a reverb accumulator past the output range, then emit at full master
    repeat (6) send(MODE_REVERB, 16'h7fff, 16'h8000, 16'h0, 16'h0);
    send(MODE_EOF, 16'h0, 16'h0, 16'h7fff, 16'h7fff);

    // long receiver hold-off while items keep coming
    hold_off = 1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      repeat (3) begin
        send(MODE_VOICE, rnd16(), rnd16(), rnd16(), rnd16());
        send(MODE_EOF, rnd16(), rnd16(), rnd16(), rnd16());
      end
    join

    for (int n = 0; n < 180; n++) begin
      if ($urandom_range(0, 9) == 0) md = MODE_EOF;
      else if ($urandom_range(0, 3) == 0) md = mode_t'($urandom_range(1, 2));
      else md = MODE_VOICE;
      send(md, rnd16(), rnd16(), rnd16(), rnd16());
    end
    send(MODE_EOF, 16'h0, 16'h0, 16'h7fff, 16'h0);
    s_tvalid <= 0;
    while (mix.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mix.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
